### rtl/sssl_pkg.sv
`default_nettype none

package sssl_pkg;

  typedef struct packed {
    logic [2:0] op;
    logic       cs_level;
    logic       mrdy_level;
    logic [7:0] data_byte;
    logic [6:0] index;
  } cmd_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       srdy_drive;
    logic       mrdy_drive;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic       message_ready;
  } res_t;

  // write strobes into the three byte buffers
  typedef struct packed {
    logic rx_we;
    logic tx_we;
    logic msg_we;
  } mem_we_t;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_RX_BYTE  = 3'd1;
  localparam logic [2:0] OP_TX_EMPTY = 3'd2;
  localparam logic [2:0] OP_TX_LOAD  = 3'd3;
  localparam logic [2:0] OP_SEND     = 3'd4;
  localparam logic [2:0] OP_READ     = 3'd5;
  localparam logic [2:0] OP_CLEAR    = 3'd6;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TX   = 2'd1;
  localparam logic [1:0] PH_RX   = 2'd2;

  localparam logic [7:0] SYNC_BYTE = 8'h5A;
  localparam logic [8:0] LEN_BIAS  = 9'd2;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/sssl_store.sv
`default_nettype none

module sssl_store #(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire sssl_pkg::mem_we_t we,
  input  wire logic [AW-1:0]     rx_waddr,
  input  wire logic [7:0]        rx_wdata,
  input  wire logic [AW-1:0]     rx_raddr,
  output logic      [7:0]        rx_rdata,
  input  wire logic [AW-1:0]     tx_waddr,
  input  wire logic [7:0]        tx_wdata,
  input  wire logic [AW-1:0]     tx_raddr,
  output logic      [7:0]        tx_rdata,
  input  wire logic [AW-1:0]     msg_waddr,
  input  wire logic [7:0]        msg_wdata,
  input  wire logic [AW-1:0]     msg_raddr,
  output logic      [7:0]        msg_rdata
);
  import sssl_pkg::*;

  logic [7:0] rx_mem  [DEPTH];
  logic [7:0] tx_mem  [DEPTH];
  logic [7:0] msg_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we.rx_we) begin
      rx_mem[rx_waddr] <= rx_wdata;
    end
    rx_rdata <= rx_mem[rx_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.tx_we) begin
      tx_mem[tx_waddr] <= tx_wdata;
    end
    tx_rdata <= tx_mem[tx_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.msg_we) begin
      msg_mem[msg_waddr] <= msg_wdata;
    end
    msg_rdata <= msg_mem[msg_raddr];
  end

endmodule

`default_nettype wire

### rtl/spi_slave_sync_length_framer.sv
// Handshaked SPI slave framer: idle, transmit and receive phases.
// Command channel (cmd_valid/cmd_stall/cmd) carries one operation per
// transaction: pin tick, received byte, transmitter empty, tx buffer load,
// start send, message read or flag clear. Each command gives exactly one
// transaction on the result channel (res_valid/res_stall/res) with the
// phase, the SRDY/MRDY levels, any byte for the transmitter, read data and
// the new-message flag.
// The sequencer takes one command at a time: cmd_stall is high from
// acceptance until the result is loaded into the output register.
// Simple commands pass through an execute and a done step; commands that
// read a buffer (tx empty, start send, message read) add a read step
// between the two. A chip-select rise in receive with a valid sync byte
// copies length+2 bytes (at most the buffer size) through one buffer read
// port, one byte a cycle.
// Reset puts the framer in idle with SRDY and MRDY high and no message;
// buffer contents are not cleared. A stalled result holds in the output
// register and the next command may be taken meanwhile; its own result
// waits until the register frees.
`default_nettype none

module spi_slave_sync_length_framer #(
  parameter int BUFFER_BYTES = 128
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire sssl_pkg::cmd_t cmd,
  output logic                res_valid,
  input  wire logic           res_stall,
  output sssl_pkg::res_t      res
);
  import sssl_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_BYTES);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_EXEC  = 9'b000000010,
    ST_TXRD  = 9'b000000100,
    ST_LEN   = 9'b000001000,
    ST_MSGRD = 9'b000010000,
    ST_SYNC0 = 9'b000100000,
    ST_SYNC1 = 9'b001000000,
    ST_COPY  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  state_t        state;
  cmd_t          cmd_q;
  logic [1:0]    phase_reg;
  logic [CW-1:0] rx_ptr;
  logic          msg_flag;
  logic [CW-1:0] tx_remaining;
  logic [CW-1:0] tx_pos;
  logic          tx_en;
  logic          srdy;
  logic          mrdy;
  logic          txv;
  logic [7:0]    txb;
  logic [7:0]    rd;
  logic          sync_ok;
  logic [CW-1:0] copy_len;
  logic [CW-1:0] copy_cnt;
  logic          wr_pend;
  logic [AW-1:0] wr_addr;

  mem_we_t       we;
  logic [AW-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr, msg_waddr, msg_raddr;
  logic [7:0]    rx_wdata, rx_rdata, tx_wdata, tx_rdata, msg_wdata, msg_rdata;

  logic rx_room;
  logic idx_ok;
  logic copy_more;

  function automatic logic [CW-1:0] clamp_len(input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, b} + LEN_BIAS;
    if (s > 9'(BUFFER_BYTES)) begin
      return DEPTH_C;
    end
    return s[CW-1:0];
  endfunction

  assign rx_room   = rx_ptr < DEPTH_C;
  assign idx_ok    = 32'(cmd_q.index) < 32'(BUFFER_BYTES);
  assign copy_more = copy_cnt < copy_len;
  assign cmd_stall = state != ST_IDLE;

  sssl_store #(.DEPTH(BUFFER_BYTES)) u_store (
    .clk      (clk),
    .we       (we),
    .rx_waddr (rx_waddr),
    .rx_wdata (rx_wdata),
    .rx_raddr (rx_raddr),
    .rx_rdata (rx_rdata),
    .tx_waddr (tx_waddr),
    .tx_wdata (tx_wdata),
    .tx_raddr (tx_raddr),
    .tx_rdata (tx_rdata),
    .msg_waddr(msg_waddr),
    .msg_wdata(msg_wdata),
    .msg_raddr(msg_raddr),
    .msg_rdata(msg_rdata)
  );

  always_comb begin
    we        = '0;
    rx_waddr  = rx_ptr[AW-1:0];
    rx_wdata  = rev8(cmd_q.data_byte);
    tx_waddr  = AW'(cmd_q.index);
    tx_wdata  = cmd_q.data_byte;
    msg_waddr = wr_addr;
    msg_wdata = rx_rdata;
    rx_raddr  = '0;
    tx_raddr  = tx_pos[AW-1:0];
    msg_raddr = AW'(cmd_q.index);
    case (state)
      ST_EXEC: begin
        we.rx_we = (cmd_q.op == OP_RX_BYTE) && rx_room;
        we.tx_we = (cmd_q.op == OP_TX_LOAD) && idx_ok;
        if (cmd_q.op == OP_SEND) begin
          tx_raddr = AW'(1);  // length byte
        end
      end
      ST_SYNC0: rx_raddr = AW'(1);
      ST_COPY: begin
        rx_raddr  = copy_cnt[AW-1:0];
        we.msg_we = wr_pend;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase_reg    <= PH_IDLE;
      rx_ptr       <= '0;
      msg_flag     <= 1'b0;
      tx_remaining <= '0;
      tx_pos       <= '0;
      tx_en        <= 1'b0;
      srdy         <= 1'b1;
      mrdy         <= 1'b1;
      wr_pend      <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != ST_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd;
            txv   <= 1'b0;
            txb   <= '0;
            rd    <= '0;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (cmd_q.op)
            OP_TICK: begin
              // end of frame in receive: rx[0] read is under way
              state <= (phase_reg == PH_RX && cmd_q.cs_level) ? ST_SYNC0 : ST_DONE;
              if (phase_reg == PH_IDLE) begin
                if (!cmd_q.cs_level) begin
                  srdy <= 1'b0;
                  if (!cmd_q.mrdy_level) begin
                    phase_reg <= PH_TX;
                  end else begin
                    phase_reg <= PH_RX;
                    rx_ptr    <= '0;
                  end
                end
              end else if (phase_reg == PH_TX) begin
                if (cmd_q.cs_level) begin
                  mrdy      <= 1'b1;
                  phase_reg <= PH_IDLE;
                end
              end
            end
            OP_RX_BYTE: begin
              if (rx_room) begin
                rx_ptr <= rx_ptr + CW'(1);
              end
              srdy  <= 1'b1;
              state <= ST_DONE;
            end
            OP_TX_EMPTY: begin
              state <= (tx_en && tx_remaining != '0 && tx_pos < DEPTH_C) ? ST_TXRD : ST_DONE;
              if (tx_en) begin
                if (tx_remaining != '0) begin
                  tx_remaining <= tx_remaining - CW'(1);
                  txv          <= 1'b1;
                  if (tx_pos < DEPTH_C) begin
                    tx_pos <= tx_pos + CW'(1);
                  end
                end else begin
                  tx_en <= 1'b0;
                end
              end
            end
            OP_SEND: begin
              tx_pos <= '0;
              tx_en  <= 1'b1;
              mrdy   <= 1'b0;
              srdy   <= 1'b1;
              state  <= ST_LEN;
            end
            OP_READ: state <= idx_ok ? ST_MSGRD : ST_DONE;
            OP_CLEAR: begin
              msg_flag <= 1'b0;
              state    <= ST_DONE;
            end
            default: state <= ST_DONE;
          endcase
        end
        ST_TXRD: begin
          txb   <= rev8(tx_rdata);
          state <= ST_DONE;
        end
        ST_LEN: begin
          tx_remaining <= clamp_len(tx_rdata);
          state        <= ST_DONE;
        end
        ST_MSGRD: begin
          rd    <= msg_rdata;
          state <= ST_DONE;
        end
        ST_SYNC0: begin
          sync_ok <= rx_rdata == SYNC_BYTE;
          state   <= ST_SYNC1;
        end
        ST_SYNC1: begin
          copy_len <= clamp_len(rx_rdata);
          copy_cnt <= '0;
          wr_pend  <= 1'b0;
          if (sync_ok) begin
            state <= ST_COPY;
          end else begin
            rx_ptr    <= '0;
            srdy      <= 1'b1;
            phase_reg <= PH_IDLE;
            state     <= ST_DONE;
          end
        end
        ST_COPY: begin
          // read of entry n overlaps write of entry n-1
          if (copy_more) begin
            wr_addr  <= copy_cnt[AW-1:0];
            wr_pend  <= 1'b1;
            copy_cnt <= copy_cnt + CW'(1);
          end else if (wr_pend) begin
            wr_pend <= 1'b0;
          end else begin
            msg_flag  <= 1'b1;
            rx_ptr    <= '0;
            srdy      <= 1'b1;
            phase_reg <= PH_IDLE;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid         <= 1'b1;
            res.phase         <= phase_reg;
            res.srdy_drive    <= srdy;
            res.mrdy_drive    <= mrdy;
            res.tx_valid      <= txv;
            res.tx_byte       <= txb;
            res.read_data     <= rd;
            res.message_ready <= msg_flag;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> state == ST_EXEC)
    else $error("accepted command did not start execution");

  a_copy_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_COPY |-> copy_cnt <= copy_len)
    else $error("copy counter ran past frame length");

  a_rx_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    rx_ptr <= DEPTH_C)
    else $error("receive pointer beyond buffer");

  a_tx_rem_bound: assert property (@(posedge clk) disable iff (rst)
    tx_remaining <= DEPTH_C)
    else $error("transmit count beyond buffer");

  a_res_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_DONE))
    else $error("result loaded outside the done step");
`endif

endmodule

`default_nettype wire

### dv/tb_spi_slave_sync_length_framer.sv
module tb_spi_slave_sync_length_framer;
  import sssl_pkg::*;

  localparam int BUF_BYTES = 128;
  localparam int ITEMS = 1600;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  // two copies of the framer state: one steers the generator, one checks the DUT
  localparam int GEN = 0;
  localparam int CHK = 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  spi_slave_sync_length_framer dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always #5 clk = ~clk;

  bit [1:0] phase_q [2];
  bit [7:0] rx_buf [2][BUF_BYTES];
  bit       rx_fill [2][BUF_BYTES];
  bit [7:0] rx_ptr [2];
  bit [7:0] msg_buf [2][BUF_BYTES];
  bit       msg_fill [2][BUF_BYTES];
  bit       msg_flag [2];
  bit [7:0] tx_buf [2][BUF_BYTES];
  bit       tx_fill [2][BUF_BYTES];
  bit [7:0] tx_left [2];
  bit [7:0] tx_pos [2];
  bit       tx_on [2];
  bit       srdy_q [2] = '{1'b1, 1'b1};
  bit       mrdy_q [2] = '{1'b1, 1'b1};

  cmd_t cmd_queue [$];
  res_t res_due [$];
  res_t want;
  int   cmds_made = 0;
  int   mismatches = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   send_gap = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  function automatic logic [7:0] bit_rev(logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7-i];
    return r;
  endfunction

  // length byte plus header, never past the buffer
  function automatic int frame_len(logic [7:0] b);
    return (int'(b) + 2 > BUF_BYTES) ? BUF_BYTES : int'(b) + 2;
  endfunction

  function automatic res_t frame_step(int v, cmd_t c);
    res_t r;
    int n;
    r = '0;
    case (c.op)
      OP_TICK: begin
        if (phase_q[v] == PH_IDLE) begin
          if (!c.cs_level) begin
            srdy_q[v] = 1'b0;
            if (!c.mrdy_level) begin
              phase_q[v] = PH_TX;
            end else begin
              phase_q[v] = PH_RX;
              rx_ptr[v] = 0;
            end
          end
        end else if (phase_q[v] == PH_TX) begin
          if (c.cs_level) begin
            mrdy_q[v] = 1'b1;
            phase_q[v] = PH_IDLE;
          end
        end else if (c.cs_level) begin
          if (rx_buf[v][0] == SYNC_BYTE) begin
            n = frame_len(rx_buf[v][1]);
            for (int i = 0; i < n; i++) begin
              msg_buf[v][i] = rx_buf[v][i];
              msg_fill[v][i] = 1'b1;
            end
            msg_flag[v] = 1'b1;
          end
          rx_ptr[v] = 0;
          srdy_q[v] = 1'b1;
          phase_q[v] = PH_IDLE;
        end
      end
      OP_RX_BYTE: begin
        // past the end of the buffer the byte is dropped
        if (rx_ptr[v] < BUF_BYTES) begin
          rx_buf[v][rx_ptr[v]] = bit_rev(c.data_byte);
          rx_fill[v][rx_ptr[v]] = 1'b1;
          rx_ptr[v]++;
        end
        srdy_q[v] = 1'b1;
      end
      OP_TX_EMPTY: begin
        if (tx_on[v]) begin
          if (tx_left[v] != 0) begin
            tx_left[v]--;
            if (tx_pos[v] < BUF_BYTES) begin
              r.tx_byte = bit_rev(tx_buf[v][tx_pos[v]]);
              tx_pos[v]++;
            end
            r.tx_valid = 1'b1;
          end else begin
            tx_on[v] = 1'b0;
          end
        end
      end
      OP_TX_LOAD: begin
        tx_buf[v][c.index] = c.data_byte;
        tx_fill[v][c.index] = 1'b1;
      end
      OP_SEND: begin
        tx_left[v] = frame_len(tx_buf[v][1]);
        tx_pos[v] = 0;
        tx_on[v] = 1'b1;
        mrdy_q[v] = 1'b0;
        srdy_q[v] = 1'b1;
      end
      OP_READ: r.read_data = msg_buf[v][c.index];
      OP_CLEAR: msg_flag[v] = 1'b0;
      default: ;
    endcase
    r.phase = phase_q[v];
    r.srdy_drive = srdy_q[v];
    r.mrdy_drive = mrdy_q[v];
    r.message_ready = msg_flag[v];
    return r;
  endfunction

  // Queue one command. Unwritten buffer slots it would read get filled first (a
  // message read moves to a written slot or is dropped), so no undefined contents are read.
  task automatic issue(logic [2:0] op, logic cs, logic mr, logic [7:0] d, logic [6:0] ix);
    cmd_t c;
    int n;
    bit ok;
    if (op == OP_TICK && cs && phase_q[GEN] == PH_RX) begin
      ok = 1'b0;
      while (!ok) begin
        ok = rx_fill[GEN][0];
        if (ok && rx_buf[GEN][0] == SYNC_BYTE) begin
          n = frame_len(rx_buf[GEN][1]);
          for (int i = 0; i < n; i++) ok = ok && rx_fill[GEN][i];
        end
        if (!ok) begin
          issue(OP_RX_BYTE, $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 255), $urandom_range(0, 127));
        end
      end
    end
    if (op == OP_TX_EMPTY && tx_on[GEN] && tx_left[GEN] != 0 && tx_pos[GEN] < BUF_BYTES &&
        !tx_fill[GEN][tx_pos[GEN]]) begin
      issue(OP_TX_LOAD, cs, mr, $urandom_range(0, 255), tx_pos[GEN][6:0]);
    end
    if (op == OP_SEND && !tx_fill[GEN][1]) begin
      issue(OP_TX_LOAD, cs, mr, $urandom_range(0, 255), 7'd1);
    end
    if (op == OP_READ && !msg_fill[GEN][ix]) begin
      n = 0;
      while (n < BUF_BYTES && !msg_fill[GEN][ix]) begin
        ix++;
        n++;
      end
      if (n == BUF_BYTES) return;
    end
    c.op = op;
    c.cs_level = cs;
    c.mrdy_level = mr;
    c.data_byte = d;
    c.index = ix;
    cmd_queue.push_back(c);
    void'(frame_step(GEN, c));
    cmds_made++;
  endtask

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cmd_valid && !cmd_stall) res_due.push_back(frame_step(CHK, cmd));
      if (cmd_valid && cmd_stall) begin
        // hold the stalled transaction
      end else if (send_gap > 0) begin
        send_gap--;
        cmd_valid <= 1'b0;
      end else if (cmd_queue.size() > 0 && gap_pct > 0 &&
                   $urandom_range(0, 99) < gap_pct) begin
        send_gap = $urandom_range(0, 10);
        cmd_valid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        cmd_valid <= 1'b1;
        cmd <= cmd_queue.pop_front();
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (res_due.size() == 0) begin
          $error("result transaction with nothing expected");
          mismatches++;
        end else begin
          want = res_due.pop_front();
          check_field("phase", want.phase, res.phase);
          check_field("srdy_drive", want.srdy_drive, res.srdy_drive);
          check_field("mrdy_drive", want.mrdy_drive, res.mrdy_drive);
          check_field("tx_valid", want.tx_valid, res.tx_valid);
          check_field("tx_byte", want.tx_byte, res.tx_byte);
          check_field("read_data", want.read_data, res.read_data);
          check_field("message_ready", want.message_ready, res.message_ready);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        hold_left = $urandom_range(0, 10);
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    int len;
    int body;
    int n;
    int next_turn;
    bit paused;
    int pct_menu [4];
    logic [7:0] d;
    pct_menu = '{0, 5, 20, 50};
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    issue(OP_TICK, 1'b1, 1'b1, 8'h00, 7'd0);
    issue(OP_UNUSED, 1'b0, 1'b0, 8'hFF, 7'd127);
    issue(OP_CLEAR, 1'b1, 1'b0, 8'h00, 7'd0);
    issue(OP_TX_EMPTY, 1'b0, 1'b1, 8'h00, 7'd0);  // sender not enabled
    issue(OP_TX_LOAD, 1'b0, 1'b0, 8'h00, 7'd0);
    issue(OP_TX_LOAD, 1'b0, 1'b0, 8'd1, 7'd1);
    issue(OP_TX_LOAD, 1'b0, 1'b0, 8'hFF, 7'd2);
    issue(OP_TX_LOAD, 1'b1, 1'b1, 8'hA5, 7'd127);
    issue(OP_TICK, 1'b0, 1'b0, 8'h00, 7'd0);
    issue(OP_SEND, 1'b0, 1'b0, 8'h00, 7'd0);
    repeat (4) issue(OP_TX_EMPTY, 1'b0, 1'b0, 8'h00, 7'd0);  // last one finds nothing left
    issue(OP_TX_EMPTY, 1'b0, 1'b0, 8'h00, 7'd0);
    issue(OP_TICK, 1'b0, 1'b1, 8'h00, 7'd0);
    issue(OP_TICK, 1'b1, 1'b0, 8'h00, 7'd0);
    issue(OP_TICK, 1'b0, 1'b1, 8'h00, 7'd0);
    issue(OP_RX_BYTE, 1'b0, 1'b1, bit_rev(SYNC_BYTE), 7'd0);
    issue(OP_RX_BYTE, 1'b0, 1'b1, bit_rev(8'd2), 7'd0);
    issue(OP_RX_BYTE, 1'b0, 1'b1, 8'hFF, 7'd127);
    issue(OP_RX_BYTE, 1'b0, 1'b1, 8'h00, 7'd0);
    issue(OP_TICK, 1'b1, 1'b1, 8'h00, 7'd0);
    issue(OP_READ, 1'b1, 1'b1, 8'h00, 7'd0);
    issue(OP_READ, 1'b1, 1'b1, 8'h00, 7'd3);
    issue(OP_CLEAR, 1'b1, 1'b1, 8'h00, 7'd0);

    next_turn = cmds_made;
    while (cmds_made < ITEMS) begin
      if (cmds_made >= next_turn) begin
        while (cmd_queue.size() > 4) @(posedge clk);
        if (!paused && cmds_made >= ITEMS / 2) begin
          while (cmd_queue.size() != 0 || cmd_valid || res_due.size() != 0) @(posedge clk);
          paused = 1'b1;
        end
        if (cmds_made >= ITEMS - 200) begin
          gap_pct = 0;
          stall_pct = 0;
        end else begin
          gap_pct = pct_menu[$urandom_range(0, 3)];
          stall_pct = pct_menu[$urandom_range(0, 3)];
        end
        next_turn += 200;
      end

      pick = $urandom_range(0, 99);
      n = $urandom_range(0, 29);
      len = (n < 22) ? $urandom_range(0, 12) : (n < 29) ? $urandom_range(13, 60) :
            $urandom_range(100, 255);
      if (pick < 40) begin
        // receive frame, mostly with the sync byte
        if (phase_q[GEN] != PH_IDLE)
          issue(OP_TICK, 1'b1, $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 127));
        issue(OP_TICK, 1'b0, 1'b1, $urandom_range(0, 255), $urandom_range(0, 127));
        body = len + $urandom_range(0, 4);
        if (body > 134) body = $urandom_range(126, 134);
        for (int k = 0; k < body; k++) begin
          if (k == 0) d = ($urandom_range(0, 9) != 0) ? bit_rev(SYNC_BYTE) : $urandom_range(0, 255);
          else if (k == 1) d = bit_rev(len[7:0]);
          else d = $urandom_range(0, 255);
          issue(OP_RX_BYTE, $urandom_range(0, 1), $urandom_range(0, 1), d, $urandom_range(0, 127));
          if ($urandom_range(0, 15) == 0)
            issue(OP_TICK, 1'b0, $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 127));
        end
        issue(OP_TICK, 1'b1, $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 127));
        repeat ($urandom_range(0, 3))
          issue(OP_READ, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 255),
                $urandom_range(0, (len + 1 > 127) ? 127 : len + 1));
        if ($urandom_range(0, 1))
          issue(OP_CLEAR, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 255),
                $urandom_range(0, 127));
      end else if (pick < 65) begin
        // transmit: fill the buffer, select with MRDY low, send, drain, deselect
        body = frame_len(len[7:0]);
        for (int k = 0; k < body; k++)
          issue(OP_TX_LOAD, $urandom_range(0, 1), $urandom_range(0, 1),
                (k == 1) ? len[7:0] : 8'($urandom_range(0, 255)), k[6:0]);
        if (phase_q[GEN] != PH_IDLE)
          issue(OP_TICK, 1'b1, $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 127));
        issue(OP_TICK, 1'b0, 1'b0, $urandom_range(0, 255), $urandom_range(0, 127));
        issue(OP_SEND, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 255),
              $urandom_range(0, 127));
        repeat (body + $urandom_range(0, 2))
          issue(OP_TX_EMPTY, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 255),
                $urandom_range(0, 127));
        issue(OP_TICK, 1'b1, $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 127));
      end else begin
        repeat ($urandom_range(1, 6))
          issue($urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 255), $urandom_range(0, 127));
      end
    end

    while (cmd_queue.size() != 0 || cmd_valid || res_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sssl_pkg.sv
rtl/sssl_store.sv
rtl/spi_slave_sync_length_framer.sv
dv/tb_spi_slave_sync_length_framer.sv
